### src/lfuat_pkg.sv
// ----------------------------------------------------------------------------
// lfuat_pkg
// Shared types and constants for the LFU block-cache tag store with aging.
// ----------------------------------------------------------------------------
package lfuat_pkg;

  localparam int TAG_W       = 32;
  localparam int CNT_W       = 8;
  localparam int SLOT_W      = 6;
  localparam int OUT_TDATA_W = 8;
  localparam int ENTRIES_DEF = 8;

  localparam logic [TAG_W-1:0] TAG_INVALID = '1;
  localparam logic [CNT_W-1:0] COUNT_CAP   = 8'd254;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 8'd255;
  localparam logic [CNT_W-1:0] COUNT_ONE   = 8'd1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] hit_idx;
    logic [CNT_W-1:0]  hit_cnt;
    logic [CNT_W-1:0]  least;
    logic [SLOT_W-1:0] victim;
  } scan_res_t;

endpackage

### src/lfu_aging_block_cache_tags_core.sv
// ----------------------------------------------------------------------------
// lfu_aging_block_cache_tags_core
// Fully associative block tag store with LFU replacement and count aging.
//
//   channel  dir  payload                               completes on
//   s_*      in   tuser[0]=opcode, tdata[31:0]=block    s_tvalid & s_tready
//   m_*      out  tdata[5:0]=slot, tuser[0]=hit         m_tvalid & m_tready
//   cfg_*    in   cfg_data[0]=cache_enable              cfg_valid & cfg_ready
//
// Flush returns no result; a disabled lookup goes straight to emit. A hit
// runs scan, decide, emit; a miss adds fill, with an aging pass first if the
// minimum is nonzero. Scan and aging read one entry per cycle through the
// single read port of the tag and count memories. Reset invalidates all tags and counts.
// A waiting result holds in the output register; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module lfu_aging_block_cache_tags_core import lfuat_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TAG_W-1:0]       s_tdata,   // block_number[31:0]
  input  logic [0:0]             s_tuser,   // opcode[0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // slot[5:0], zero [7:6]
  output logic [0:0]             m_tuser,   // hit[0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_data   // cache_enable[0]
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]   DEPTH = (IDX_W + 1)'(ENTRIES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_AGE    = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               en;
  logic [TAG_W-1:0]   blk;
  logic [IDX_W:0]     ctr;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [ENTRIES-1:0] tag_vld;
  logic [ENTRIES-1:0] cnt_vld;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_hit;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_hit;

  logic               accept;
  logic               issue;
  logic               last_rd;
  logic               unit_start;
  logic [TAG_W-1:0]   tag_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TAG_W-1:0]   tag_cur;
  logic [CNT_W-1:0]   cnt_cur;
  scan_res_t          res;
  logic [CNT_W-1:0]   aged;
  logic [CNT_W-1:0]   bumped;
  logic               tag_we;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [IDX_W-1:0]   hit_i;
  logic [IDX_W-1:0]   victim_i;
  logic               emit_go;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign issue     = ((state == S_SCAN) || (state == S_AGE)) && (ctr < DEPTH);
  assign last_rd   = rd_vld && (rd_idx == LAST);
  assign unit_start = accept && (s_tuser[0] == OP_LOOKUP) && en;
  assign hit_i     = res.hit_idx[IDX_W-1:0];
  assign victim_i  = res.victim[IDX_W-1:0];
  assign emit_go   = (state == S_EMIT) && (!out_valid || m_tready);

  assign tag_cur = tag_vld[rd_idx] ? tag_q : TAG_INVALID;
  assign cnt_cur = cnt_vld[rd_idx] ? cnt_q : '0;

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_slot);
  assign m_tuser  = out_hit;

  lfuat_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (victim_i),
    .wdata (blk),
    .re    (issue),
    .raddr (ctr[IDX_W-1:0]),
    .rdata (tag_q)
  );

  lfuat_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (issue),
    .raddr (ctr[IDX_W-1:0]),
    .rdata (cnt_q)
  );

  lfuat_scan_unit u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .step   (rd_vld && (state == S_SCAN)),
    .idx    (SLOT_W'(rd_idx)),
    .tag    (tag_cur),
    .cnt    (cnt_cur),
    .blk    (blk),
    .res    (res),
    .aged   (aged),
    .bumped (bumped)
  );

  always_comb begin
    tag_we    = (state == S_FILL);
    cnt_we    = 1'b0;
    cnt_waddr = victim_i;
    cnt_wdata = COUNT_ONE;
    case (state)
      S_DECIDE: begin
        cnt_we    = res.found;
        cnt_waddr = hit_i;
        cnt_wdata = bumped;
      end
      S_AGE: begin
        cnt_we    = rd_vld;
        cnt_waddr = rd_idx;
        cnt_wdata = aged;
      end
      S_FILL: begin
        cnt_we = 1'b1;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (s_tuser[0] == OP_LOOKUP)) begin
          state_next = en ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (last_rd) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (res.found) begin
          state_next = S_EMIT;
        end else if (res.least != '0) begin
          state_next = S_AGE;
        end else begin
          state_next = S_FILL;
        end
      end
      S_AGE: begin
        if (last_rd) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      en        <= 1'b1;
      tag_vld   <= '0;
      cnt_vld   <= '0;
      rd_vld    <= 1'b0;
      ctr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_valid && cfg_ready) begin
        en <= cfg_data[0];
      end
      if (issue) begin
        ctr <= ctr + 1'b1;
      end else if (state_next == S_AGE || state_next == S_SCAN) begin
        ctr <= '0;
      end
      if (accept && (s_tuser[0] == OP_FLUSH)) begin
        tag_vld <= '0;
        cnt_vld <= '0;
      end else begin
        if (accept && !en) begin
          tag_vld[LAST] <= 1'b0;
        end
        if (tag_we) begin
          tag_vld[victim_i] <= 1'b1;
        end
        if (cnt_we) begin
          cnt_vld[cnt_waddr] <= 1'b1;
        end
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ctr[IDX_W-1:0];
    if (accept) begin
      blk      <= s_tdata;
      res_slot <= SLOT_W'(LAST);
      res_hit  <= 1'b0;
    end
    if (state == S_DECIDE && res.found) begin
      res_slot <= res.hit_idx;
      res_hit  <= 1'b1;
    end
    if (state == S_FILL) begin
      res_slot <= res.victim;
      res_hit  <= 1'b0;
    end
    if (emit_go) begin
      out_slot <= res_slot;
      out_hit  <= res_hit;
    end
  end

  a_age_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE) |-> (res.least != '0))
    else $error("aging pass with zero minimum");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata < OUT_TDATA_W'(ENTRIES)))
    else $error("result slot out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser[0] == OP_FLUSH)) |=> ((tag_vld == '0) && (cnt_vld == '0)))
    else $error("flush left valid entries");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (cnt_wdata <= COUNT_CAP))
    else $error("use count above cap");

  a_hit_no_tag_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && res.found) |=> (state == S_EMIT && !tag_we))
    else $error("hit path wrote a tag");

endmodule

### src/lfuat_ram.sv
// ----------------------------------------------------------------------------
// lfuat_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lfuat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lfuat_scan_unit.sv
// ----------------------------------------------------------------------------
// lfuat_scan_unit
// Shared compare and count unit: tag match, running minimum, aging subtract
// and saturating increment.
// ----------------------------------------------------------------------------
module lfuat_scan_unit import lfuat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              step,
  input  logic [SLOT_W-1:0] idx,
  input  logic [TAG_W-1:0]  tag,
  input  logic [CNT_W-1:0]  cnt,
  input  logic [TAG_W-1:0]  blk,
  output scan_res_t         res,
  output logic [CNT_W-1:0]  aged,
  output logic [CNT_W-1:0]  bumped
);

  logic match;
  logic less;

  assign match  = (tag == blk);
  assign less   = (cnt < res.least);
  assign aged   = (cnt >= res.least) ? cnt - res.least : '0;
  assign bumped = (res.hit_cnt >= COUNT_CAP) ? COUNT_CAP : res.hit_cnt + COUNT_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.found <= 1'b0;
    end else if (start) begin
      res.found <= 1'b0;
    end else if (step && match) begin
      res.found <= 1'b1;
    end
    if (start) begin
      res.least  <= COUNT_MAX;
      res.victim <= '0;
    end else if (step) begin
      if (!res.found && match) begin
        res.hit_idx <= idx;
        res.hit_cnt <= cnt;
      end
      if (less) begin
        res.least  <= cnt;
        res.victim <= idx;
      end
    end
  end

endmodule
